### design/cms_pkg.sv
//------------------------------------------------------------------------------
// cms_pkg: shared types and constants of the complex set magnitude sorter
// Holds the data widths, the sequencer states and the square-root request.
//------------------------------------------------------------------------------
package cms_pkg;

	localparam int unsigned ValW  = 16;
	localparam int unsigned SqW   = 32;
	localparam int unsigned SumW  = 22;
	localparam int unsigned ProdW = 32;
	localparam int unsigned FracW = 8;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_MUL,
		ST_SAT,
		ST_RD_I,
		ST_RD_J,
		ST_CMP,
		ST_SWAP,
		ST_OUT_RD,
		ST_OUT_SQRT,
		ST_OUT_WAIT,
		ST_OUT_SEND
	} cms_state_t;

	typedef struct packed {
		logic             start;
		logic [SqW-1:0]   radicand;
	} cms_sqrt_req_t;

	typedef struct packed {
		logic             done;
		logic [ValW-1:0]  root;
	} cms_sqrt_rsp_t;

endpackage

### design/cms_if.sv
//------------------------------------------------------------------------------
// cms_in_if / cms_out_if: valid-ready channels of the sorter
// One transfer when valid and ready are both high at a rising edge.
//------------------------------------------------------------------------------
interface cms_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] value_re;
	logic signed [15:0] value_im;
	logic               set_end;

	modport source (output valid, value_re, value_im, set_end, input ready);
	modport sink (input valid, value_re, value_im, set_end, output ready);
endinterface

interface cms_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sorted_re;
	logic signed [15:0] sorted_im;
	logic        [15:0] magnitude;
	logic signed [21:0] sum_re;
	logic signed [21:0] sum_im;
	logic signed [31:0] prod_re;
	logic signed [31:0] prod_im;
	logic               overflow;
	logic               run_end;

	modport source (output valid, sorted_re, sorted_im, magnitude, sum_re, sum_im,
		prod_re, prod_im, overflow, run_end, input ready);
	modport sink (input valid, sorted_re, sorted_im, magnitude, sum_re, sum_im,
		prod_re, prod_im, overflow, run_end, output ready);
endinterface

### design/complex_set_magnitude_sorter.sv
//------------------------------------------------------------------------------
// complex_set_magnitude_sorter: loads a set of Q8.8 complex numbers, keeps
// their sum and saturated product, then emits them by descending magnitude.
//------------------------------------------------------------------------------
// Loading steps each item through accept, multiply, and shift and saturate,
// set by the two-step complex product update; no new item is taken until the
// last one is through. After the item that ends the set, an exchange sort runs
// over the element memory: each outer step reads element i, each compared pair
// reads element j and then compares, and a swap writes both elements back. Each
// result then passes through the 16-step square root. A number beyond MAX_ITEMS
// is dropped and sets overflow. The memory needs no clearing after reset; input
// is held off from set end until the last result transfers.
module complex_set_magnitude_sorter import cms_pkg::*; #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	cms_in_if.sink      in_ch,
	cms_out_if.source   out_ch
);

	localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam int unsigned EW = 2*ValW + SqW;

	cms_state_t state_q, state_d;

	logic [CW-1:0]           count_q;
	logic signed [SumW-1:0]  sum_re_q, sum_im_q;
	logic signed [ProdW-1:0] prod_re_q, prod_im_q;
	logic                    ovf_q;
	logic                    last_q;
	logic signed [ValW-1:0]  re_q, im_q;
	logic signed [63:0]      mr_q [2];
	logic signed [63:0]      mi_q [2];
	logic [AW-1:0]           i_q, j_q;
	logic [EW-1:0]           ei_q, ej_q;

	logic                    we;
	logic [AW-1:0]           waddr, raddr;
	logic [EW-1:0]           wdata, rdata;
	logic [EW-1:0]           rd_data;
	cms_sqrt_req_t           sq_req;
	cms_sqrt_rsp_t           sq_rsp;

	logic signed [31:0]      sq_re, sq_im;
	logic signed [63:0]      sh_re, sh_im;
	logic [CW-1:0]           i_ext, j_ext;

	// second write of a swap and read bypass
	logic                    swap2_s1;
	logic [AW-1:0]           swap_j_s1;
	logic [EW-1:0]           swap_d_s1;
	logic                    byp_s1;
	logic [EW-1:0]           byp_d_s1;

	cms_store #(.DEPTH(MAX_ITEMS)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	cms_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	assign i_ext = CW'(i_q);
	assign j_ext = CW'(j_q);
	assign sq_re = 32'(re_q) * 32'(re_q);
	assign sq_im = 32'(im_q) * 32'(im_q);
	assign sh_re = (mr_q[0] - mr_q[1]) >>> FracW;
	assign sh_im = (mi_q[0] + mi_q[1]) >>> FracW;

	// take the written word when the read hit the entry written in the same cycle
	assign rd_data = byp_s1 ? byp_d_s1 : rdata;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory and root control
	always_comb begin
		state_d       = state_q;
		we            = 1'b0;
		waddr         = count_q[AW-1:0];
		wdata         = {re_q, im_q, 32'(sq_re + sq_im)};
		raddr         = i_q;
		sq_req.start  = 1'b0;
		sq_req.radicand = rd_data[SqW-1:0];
		in_ch.ready   = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					if (count_q < CW'(MAX_ITEMS)) begin
						state_d = ST_MUL;
					end else if (in_ch.set_end) begin
						state_d = ST_RD_I;
					end
				end
			end
			ST_MUL: begin
				we      = 1'b1;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				state_d = last_q ? ST_RD_I : ST_LOAD;
			end
			ST_RD_I: begin
				raddr = i_q;
				if (i_ext + CW'(1) >= count_q) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_RD_J;
				end
			end
			ST_RD_J: begin
				raddr   = j_q;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (ei_q[SqW-1:0] < rd_data[SqW-1:0]) begin
					state_d = ST_SWAP;
				end else if (j_ext + CW'(1) >= count_q) begin
					state_d = ST_RD_I;
				end else begin
					state_d = ST_RD_J;
				end
			end
			ST_SWAP: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = ej_q;
				if (j_ext + CW'(1) >= count_q) begin
					state_d = ST_RD_I;
				end else begin
					state_d = ST_RD_J;
				end
			end
			ST_OUT_RD: begin
				raddr   = i_q;
				state_d = ST_OUT_SQRT;
			end
			ST_OUT_SQRT: begin
				sq_req.start = 1'b1;
				state_d      = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (sq_rsp.done) begin
					state_d = ST_OUT_SEND;
				end
			end
			ST_OUT_SEND: begin
				if (out_ch.ready) begin
					state_d = out_ch.run_end ? ST_LOAD : ST_OUT_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
		// the cycle after a swap: write old element i to j
		if (swap2_s1) begin
			we    = 1'b1;
			waddr = swap_j_s1;
			wdata = swap_d_s1;
		end
	end

	// control and accumulator registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sum_re_q  <= '0;
			sum_im_q  <= '0;
			prod_re_q <= ProdW'(256);
			prod_im_q <= '0;
			ovf_q     <= 1'b0;
			last_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					i_q <= '0;
					if (in_ch.valid) begin
						last_q <= in_ch.set_end;
						if (count_q >= CW'(MAX_ITEMS)) begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					count_q  <= count_q + CW'(1);
					sum_re_q <= sum_re_q + SumW'(re_q);
					sum_im_q <= sum_im_q + SumW'(im_q);
				end
				ST_SAT: begin
					if (sh_re > 64'sh7FFF_FFFF) begin
						prod_re_q <= 32'sh7FFF_FFFF;
						ovf_q     <= 1'b1;
					end else if (sh_re < -64'sh8000_0000) begin
						prod_re_q <= 32'sh8000_0000;
						ovf_q     <= 1'b1;
					end else begin
						prod_re_q <= sh_re[31:0];
					end
					if (sh_im > 64'sh7FFF_FFFF) begin
						prod_im_q <= 32'sh7FFF_FFFF;
						ovf_q     <= 1'b1;
					end else if (sh_im < -64'sh8000_0000) begin
						prod_im_q <= 32'sh8000_0000;
						ovf_q     <= 1'b1;
					end else begin
						prod_im_q <= sh_im[31:0];
					end
				end
				ST_RD_I: begin
					j_q <= i_q + AW'(1);
					if (i_ext + CW'(1) >= count_q) begin
						i_q <= '0;
					end
				end
				ST_CMP: begin
					if (!(ei_q[SqW-1:0] < rd_data[SqW-1:0])) begin
						if (j_ext + CW'(1) >= count_q) begin
							i_q <= i_q + AW'(1);
						end else begin
							j_q <= j_q + AW'(1);
						end
					end
				end
				ST_SWAP: begin
					if (j_ext + CW'(1) >= count_q) begin
						i_q <= i_q + AW'(1);
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				ST_OUT_WAIT: begin
					if (sq_rsp.done) begin
						out_ch.valid <= 1'b1;
					end
				end
				ST_OUT_SEND: begin
					if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						i_q          <= i_q + AW'(1);
						if (out_ch.run_end) begin
							count_q   <= '0;
							sum_re_q  <= '0;
							sum_im_q  <= '0;
							prod_re_q <= ProdW'(256);
							prod_im_q <= '0;
							ovf_q     <= 1'b0;
							i_q       <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers: input capture, partial products, sort operands, result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				re_q <= in_ch.value_re;
				im_q <= in_ch.value_im;
			end
			ST_MUL: begin
				mr_q[0] <= 64'(prod_re_q) * 64'(re_q);
				mr_q[1] <= 64'(prod_im_q) * 64'(im_q);
				mi_q[0] <= 64'(prod_re_q) * 64'(im_q);
				mi_q[1] <= 64'(prod_im_q) * 64'(re_q);
			end
			ST_RD_J: begin
				// element i arrives on the first compare of its row
				if (j_ext == i_ext + CW'(1)) begin
					ei_q <= rd_data;
				end
			end
			ST_CMP: begin
				ej_q <= rd_data;
			end
			ST_SWAP: begin
				// element j becomes the new element i
				ei_q <= ej_q;
			end
			ST_OUT_SQRT: begin
				out_ch.sorted_re <= rd_data[EW-1 -: ValW];
				out_ch.sorted_im <= rd_data[SqW +: ValW];
				out_ch.run_end   <= (i_ext + CW'(1) == count_q);
			end
			ST_OUT_WAIT: begin
				out_ch.magnitude <= sq_rsp.root;
			end
			default: ;
		endcase
	end

	// register the second swap write and the bypass flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap2_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			swap2_s1 <= (state_q == ST_SWAP);
			byp_s1   <= we && (waddr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		swap_j_s1 <= j_q;
		swap_d_s1 <= ei_q;
		byp_d_s1  <= wdata;
	end

	assign out_ch.sum_re   = sum_re_q;
	assign out_ch.sum_im   = sum_im_q;
	assign out_ch.prod_re  = prod_re_q;
	assign out_ch.prod_im  = prod_im_q;
	assign out_ch.overflow = ovf_q;

endmodule

### design/cms_store.sv
//------------------------------------------------------------------------------
// cms_store: element memory of the sorter
// One write port and one read port, read data registered.
//------------------------------------------------------------------------------
module cms_store import cms_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [2*ValW+SqW-1:0]    wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [2*ValW+SqW-1:0]    rdata
);

	logic [2*ValW+SqW-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/cms_sqrt.sv
//------------------------------------------------------------------------------
// cms_sqrt: iterative integer square root
// Resolves one result bit per cycle.
//------------------------------------------------------------------------------
module cms_sqrt import cms_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cms_sqrt_req_t req,
	output cms_sqrt_rsp_t rsp
);

	logic [SqW-1:0]  rem_q;
	logic [SqW-1:0]  res_q;
	logic [SqW-1:0]  bit_q;
	logic            busy_q;
	logic            done_q;
	logic [SqW-1:0]  trial;

	assign trial = res_q + bit_q;

	// run the digit recurrence, one step a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				rem_q  <= req.radicand;
				res_q  <= '0;
				bit_q  <= SqW'(1) << (SqW - 2);
			end else if (busy_q) begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q == SqW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{done: done_q, root: res_q[ValW-1:0]};

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb: regression bench of the complex set magnitude sorter
// Sends sets of Q8.8 complex numbers, predicts the sorted output set with its
// sum, saturated product and overflow flag, and checks every result transfer
// in order against the predicted list.
//------------------------------------------------------------------------------
module tb import cms_pkg::*; ();

	localparam int unsigned CAP        = 64;
	localparam int unsigned CYCLE_CAP  = 1500000;
	localparam int unsigned DRAIN_WAIT = 300;

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic        [15:0] mag;
		logic signed [21:0] sum_re;
		logic signed [21:0] sum_im;
		logic signed [31:0] prod_re;
		logic signed [31:0] prod_im;
		logic               ovf;
		logic               last;
	} sorted_elem_t;

	logic clk;
	logic arst_n;

	cms_in_if  in_ch ();
	cms_out_if out_ch ();

	complex_set_magnitude_sorter #(.MAX_ITEMS(CAP)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// predictor state for the set being loaded
	logic signed [15:0] set_re [CAP];
	logic signed [15:0] set_im [CAP];
	logic        [31:0] set_sq [CAP];
	int unsigned        set_count;
	logic signed [21:0] run_sum_re;
	logic signed [21:0] run_sum_im;
	longint             run_prod_re;
	longint             run_prod_im;
	logic               run_ovf;

	sorted_elem_t pending_sorted [$];

	int unsigned errors;
	int unsigned cycles;
	bit          gaps_on;
	bit          long_hold;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [15:0] floor_root(logic [31:0] v);
		logic [15:0] r;
		logic [15:0] t;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (16'd1 << b);
			if (longint'(t) * longint'(t) <= longint'(v))
				r = t;
		end
		return r;
	endfunction

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) begin
			run_ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			run_ovf = 1'b1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	task automatic clear_set();
		set_count   = 0;
		run_sum_re  = '0;
		run_sum_im  = '0;
		run_prod_re = 256;
		run_prod_im = 0;
		run_ovf     = 1'b0;
	endtask

	// fold one accepted number into the set; on set end, sort and queue results
	task automatic predict_number(logic signed [15:0] re, logic signed [15:0] im, logic fin);
		longint       nr;
		longint       ni;
		logic signed [15:0] tr;
		logic signed [15:0] ti;
		logic [31:0]  tq;
		sorted_elem_t e;
		if (set_count < CAP) begin
			nr = run_prod_re * longint'(re) - run_prod_im * longint'(im);
			ni = run_prod_re * longint'(im) + run_prod_im * longint'(re);
			set_re[set_count] = re;
			set_im[set_count] = im;
			set_sq[set_count] = 32'(int'(re) * int'(re)) + 32'(int'(im) * int'(im));
			set_count++;
			run_sum_re  = run_sum_re + 22'(re);
			run_sum_im  = run_sum_im + 22'(im);
			run_prod_re = clamp32(nr >>> FracW);
			run_prod_im = clamp32(ni >>> FracW);
		end else begin
			run_ovf = 1'b1;
		end
		if (!fin)
			return;
		// exchange sort: swap only on strictly smaller
		for (int i = 0; i < set_count; i++) begin
			for (int j = i + 1; j < set_count; j++) begin
				if (set_sq[i] < set_sq[j]) begin
					tr = set_re[i]; ti = set_im[i]; tq = set_sq[i];
					set_re[i] = set_re[j]; set_im[i] = set_im[j]; set_sq[i] = set_sq[j];
					set_re[j] = tr; set_im[j] = ti; set_sq[j] = tq;
				end
			end
		end
		for (int i = 0; i < set_count; i++) begin
			e.re      = set_re[i];
			e.im      = set_im[i];
			e.mag     = floor_root(set_sq[i]);
			e.sum_re  = run_sum_re;
			e.sum_im  = run_sum_im;
			e.prod_re = 32'(run_prod_re);
			e.prod_im = 32'(run_prod_im);
			e.ovf     = run_ovf;
			e.last    = (i + 1 == set_count);
			pending_sorted.push_back(e);
		end
		clear_set();
	endtask

	// send one number: optional idle burst, then hold until the transfer
	task automatic send_number(logic signed [15:0] re, logic signed [15:0] im, logic fin);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.value_re <= re;
		in_ch.value_im <= im;
		in_ch.set_end  <= fin;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_number(re, im, fin);
	endtask

	// stop offering and wait until every queued result has transferred
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_sorted.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
				long_hold = 1'b0;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t ns: mismatch on %s: expected %0d, actual %0d", $realtime, name,
				want, got);
			errors++;
		end
	endtask

	// compare each result transfer with the oldest predicted element
	always @(posedge clk) begin
		sorted_elem_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_sorted.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual re=%0d im=%0d",
					$realtime, out_ch.sorted_re, out_ch.sorted_im);
				errors++;
			end else begin
				e = pending_sorted.pop_front();
				check_field("sorted_re", e.re, out_ch.sorted_re);
				check_field("sorted_im", e.im, out_ch.sorted_im);
				check_field("magnitude", e.mag, out_ch.magnitude);
				check_field("sum_re", e.sum_re, out_ch.sum_re);
				check_field("sum_im", e.sum_im, out_ch.sum_im);
				check_field("prod_re", e.prod_re, out_ch.prod_re);
				check_field("prod_im", e.prod_im, out_ch.prod_im);
				check_field("overflow", e.ovf, out_ch.overflow);
				check_field("run_end", e.last, out_ch.run_end);
			end
		end
	end

	// extremes of both parts, zero and a one-number set
	task automatic test_extremes();
		send_number(16'sh7fff, 16'sh7fff, 1'b0);
		send_number(-16'sh8000, -16'sh8000, 1'b0);
		send_number(16'sd0, 16'sd0, 1'b0);
		send_number(-16'sh8000, 16'sh7fff, 1'b0);
		send_number(16'sd1, -16'sd1, 1'b1);
		send_number(-16'sh8000, 16'sd0, 1'b1);
		drain();
	endtask

	// equal magnitudes must keep the exchange-sort order
	task automatic test_ties();
		send_number(16'sd768, 16'sd1024, 1'b0);
		send_number(16'sd1024, 16'sd768, 1'b0);
		send_number(-16'sd1280, 16'sd0, 1'b0);
		send_number(16'sd0, 16'sd1280, 1'b0);
		send_number(16'sd256, 16'sd0, 1'b0);
		send_number(16'sd0, -16'sd256, 1'b1);
		drain();
	endtask

	// large factors drive the product into saturation
	task automatic test_saturation();
		repeat (5) send_number(16'sh7fff, -16'sh8000, 1'b0);
		send_number(16'sh4000, 16'sh4000, 1'b1);
		repeat (4) send_number(-16'sh8000, 16'sd0, 1'b0);
		send_number(-16'sh8000, 16'sd0, 1'b1);
		drain();
	endtask

	// fill the store, then drop numbers, the last one carrying set end
	task automatic test_full_store();
		for (int k = 0; k < CAP; k++)
			send_number(16'($urandom), 16'($urandom), 1'b0);
		send_number(16'sd5, 16'sd5, 1'b0);
		send_number(16'sd7, 16'sd7, 1'b1);
		drain();
		// exactly full, with set end on the last stored number
		for (int k = 0; k < CAP; k++)
			send_number(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), k == CAP - 1);
		drain();
	endtask

	// receiver holds off while the sender keeps offering the next set
	task automatic test_backpressure();
		long_hold = 1'b1;
		for (int k = 0; k < 6; k++)
			send_number(16'($urandom), 16'($urandom), k == 5);
		for (int k = 0; k < 4; k++)
			send_number(16'($urandom), 16'($urandom), k == 3);
		drain();
	endtask

	// random sets: mostly small, some with narrow values for ties
	task automatic test_random(int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		bit          narrow;
		logic signed [15:0] re;
		logic signed [15:0] im;
		sent = 0;
		while (sent < n_items) begin
			len    = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 10);
			narrow = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				re = narrow ? 16'($signed($urandom_range(0, 6)) - 3) : 16'($urandom);
				im = narrow ? 16'($signed($urandom_range(0, 6)) - 3) : 16'($urandom);
				send_number(re, im, k == len - 1);
				sent++;
			end
			if (sent > n_items / 2)
				gaps_on = 1'b0;
		end
		drain();
	endtask

	initial begin
		errors    = 0;
		cycles    = 0;
		gaps_on   = 1'b1;
		long_hold = 1'b0;
		clear_set();
		arst_n          = 1'b0;
		in_ch.valid    <= 1'b0;
		in_ch.value_re <= '0;
		in_ch.value_im <= '0;
		in_ch.set_end  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_ties();
		test_saturation();
		test_full_store();
		test_backpressure();
		test_random(250);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
